// ===== rtl/core/pfi_pkg.sv =====
// Shared constants and control structs of the polyphase FIR interpolator.
package pfi_pkg;

    localparam int RATIO_DEF      = 2;
    localparam int TAPS_DEF       = 63;
    localparam int PHASE_TAPS_DEF = 32;

    localparam int SAMPLE_W = 24;              // Q1.23 samples
    localparam int COEF_W   = 18;              // Q2.16 coefficients
    localparam int FRAC_W   = 16;              // coefficient fraction bits
    localparam int DIGIT_W  = 8;               // sample bits per multiply cycle
    localparam int DIGITS   = SAMPLE_W / DIGIT_W;
    localparam int DIG_CW   = $clog2(DIGITS);

    // One multiply step handed to the MAC
    typedef struct packed {
        logic              valid;
        logic [DIG_CW-1:0] digit;   // digit position within the sample
        logic              clear;   // first digit of the first tap
        logic              done;    // last digit of the last tap
        logic              last_br; // step belongs to the last branch
    } mac_ctl_t;

    // What the MAC reports back
    typedef struct packed {
        logic                valid; // finished branch result
        logic                busy;  // accumulate stage still working
        logic                last;
        logic [SAMPLE_W-1:0] sample;
    } mac_res_t;

endpackage

// ===== rtl/core/pfi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pfi_ram #(
    parameter int WIDTH = pfi_pkg::SAMPLE_W,
    parameter int DEPTH = pfi_pkg::PHASE_TAPS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pfi_mac.sv =====
// Digit-serial multiply-accumulate with rounding and saturation of the branch sum.
module pfi_mac #(
    parameter int PHASE_TAPS = pfi_pkg::PHASE_TAPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pfi_pkg::mac_ctl_t                   ctl,
    input  logic signed [pfi_pkg::COEF_W-1:0]   coef,
    input  logic [pfi_pkg::SAMPLE_W-1:0]        smp,
    input  logic                                smp_ok,
    output pfi_pkg::mac_res_t                   res
);

    localparam int DW     = pfi_pkg::DIGIT_W;
    localparam int SW     = pfi_pkg::SAMPLE_W;
    localparam int PP_W   = pfi_pkg::COEF_W + DW + 1;
    localparam int ACC_W  = pfi_pkg::COEF_W + SW + $clog2(PHASE_TAPS) + 1;
    localparam int FW     = pfi_pkg::FRAC_W;
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(2 ** (FW - 1));
    localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'(2 ** (SW - 1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN  = ACC_W'(-(2 ** (SW - 1)));

    logic [SW-1:0]            masked;
    logic [DW-1:0]            digit;
    logic                     top_dig;
    logic signed [DW:0]       dig_ext;
    logic signed [PP_W-1:0]   pp_next;
    logic [SW-DW-1:0]         sh_reg;
    logic [SW-DW-1:0]         sh_next;
    logic signed [PP_W-1:0]   pp_reg;
    pfi_pkg::mac_ctl_t        cctl_reg;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     fin_reg;
    logic                     fin_last_reg;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  quo;
    logic [SW-1:0]            sat_val;

    // Digit pick: digit 0 straight from memory, later digits from the shift register
    always_comb
    begin
        masked  = smp_ok ? smp : '0;
        top_dig = (ctl.digit == pfi_pkg::DIG_CW'(pfi_pkg::DIGITS - 1));
        if (ctl.digit == '0)
        begin
            digit   = masked[DW-1:0];
            sh_next = masked[SW-1:DW];
        end
        else
        begin
            digit   = sh_reg[DW-1:0];
            sh_next = sh_reg >> DW;
        end
        // only the top digit carries the sample's sign
        dig_ext = {top_dig & digit[DW-1], digit};
        pp_next = coef * dig_ext;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            sh_reg <= sh_next;
            pp_reg <= pp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cctl_reg <= '0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            cctl_reg <= ctl;
            fin_reg  <= cctl_reg.valid & cctl_reg.done;
        end
    end

    // Weight the partial product by its digit position and accumulate
    always_comb
    begin
        addend   = ACC_W'(pp_reg);
        addend   = addend <<< (cctl_reg.digit * DW);
        acc_next = (cctl_reg.clear ? '0 : acc_reg) + addend;
    end

    always_ff @(posedge clk)
    begin
        if (cctl_reg.valid)
        begin
            acc_reg      <= acc_next;
            fin_last_reg <= cctl_reg.last_br;
        end
    end

    // Round half up, then clamp to the sample range
    always_comb
    begin
        rnd = acc_reg + HALF_LSB;
        quo = rnd >>> FW;
        if (quo > SAT_MAX)
        begin
            sat_val = SW'(SAT_MAX);
        end
        else if (quo < SAT_MIN)
        begin
            sat_val = SW'(SAT_MIN);
        end
        else
        begin
            sat_val = SW'(quo);
        end
    end

    assign res.valid  = fin_reg;
    assign res.busy   = cctl_reg.valid;
    assign res.last   = fin_last_reg;
    assign res.sample = sat_val;

endmodule

// ===== rtl/core/polyphase_fir_interpolator_top.sv =====
// Top level of the polyphase FIR interpolator: sequencer, history, coefficient ROM, output word.
// Each accepted input word is written into a PHASE_TAPS-deep history and produces RATIO
// output words, branch 0 first, the last one flagged on m_tlast. A branch is computed by
// one digit-serial MAC that takes a sample 8 bits at a time, one digit per multiply step. A
// stalled sink holds the next branch until its word is taken. The next input word is
// accepted once the last branch's result sits in the output register. Coefficients are
// a Blackman-windowed sinc computed when the design elaborates; the history reads as
// zero after reset.
module polyphase_fir_interpolator_top #(
    parameter int RATIO      = pfi_pkg::RATIO_DEF,
    parameter int TAPS       = pfi_pkg::TAPS_DEF,
    parameter int PHASE_TAPS = pfi_pkg::PHASE_TAPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pfi_pkg::SAMPLE_W-1:0]  s_tdata,   // [23:0] sample_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pfi_pkg::SAMPLE_W-1:0]  m_tdata,   // [23:0] sample_out
    output logic                          m_tlast    // last_of_run
);

    localparam int SW     = pfi_pkg::SAMPLE_W;
    localparam int CW     = pfi_pkg::COEF_W;
    localparam int DCW    = pfi_pkg::DIG_CW;
    localparam int NCOEF  = RATIO * PHASE_TAPS;
    localparam int PTR_W  = $clog2(PHASE_TAPS);
    localparam int BR_W   = $clog2(RATIO);
    localparam int CIDX_W = $clog2(NCOEF);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    // Kernel design constants, Q30
    localparam longint QONE        = 64'sd1073741824;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint W_A0        = (longint'(42) <<< 30) / 100;
    localparam longint W_A1        = (longint'(50) <<< 30) / 100;
    localparam longint W_A2        = (longint'(8) <<< 30) / 100;
    localparam longint CENTRE      = (TAPS - 1) / 2;
    localparam longint KDEN        = 2 * RATIO;
    localparam longint SPAN        = 4 * (TAPS - 1);

    typedef logic signed [CW-1:0] coef_rom_t [NCOEF];

    // sine of a 32-bit turn fraction, Q30, odd Taylor series to x^11
    function automatic longint sin_ph(longint ph);
        logic [1:0] q;
        longint f;
        longint x;
        longint x2;
        longint t;
        longint s;
        q = 2'(ph >>> 30);
        f = ph & 64'sh3FFF_FFFF;
        if (q[0])
        begin
            f = QONE - f;
        end
        x  = (f * HALF_PI_Q30) >>> 30;
        x2 = (x * x) >>> 30;
        t  = QONE;
        t  = QONE - ((x2 * t) >>> 30) / 110;
        t  = QONE - ((x2 * t) >>> 30) / 72;
        t  = QONE - ((x2 * t) >>> 30) / 42;
        t  = QONE - ((x2 * t) >>> 30) / 20;
        t  = QONE - ((x2 * t) >>> 30) / 6;
        s  = (x * t) >>> 30;
        return q[1] ? -s : s;
    endfunction

    function automatic longint sin_kden(longint num);
        longint r;
        r = num % KDEN;
        if (r < 0)
        begin
            r = r + KDEN;
        end
        return sin_ph((r <<< 32) / KDEN);
    endfunction

    function automatic longint sin_span(longint num);
        longint r;
        r = num % SPAN;
        if (r < 0)
        begin
            r = r + SPAN;
        end
        return sin_ph((r <<< 32) / SPAN);
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return (a * b) / QONE;
    endfunction

    // signed division truncated toward zero, by shift and subtract
    function automatic longint div_trunc(longint a, longint b);
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned rem;
        longint unsigned quo;
        int              i;
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        rem = '0;
        quo = '0;
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], ua[i]};
            if (rem >= ub)
            begin
                rem    = rem - ub;
                quo[i] = 1'b1;
            end
        end
        return ((a < 0) != (b < 0)) ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic longint kern_h(int n);
        longint d;
        longint g;
        longint w;
        d = longint'(n) - CENTRE;
        if (d == 0)
        begin
            g = PI_Q30 / RATIO;
        end
        else
        begin
            g = div_trunc(sin_kden(d), d);
        end
        w = W_A0 - mul_q30(W_A1, sin_span(longint'(4 * n + TAPS - 1)))
                 + mul_q30(W_A2, sin_span(longint'(8 * n + TAPS - 1)));
        return mul_q30(g, w);
    endfunction

    function automatic coef_rom_t build_rom();
        coef_rom_t rom;
        longint    sum;
        longint    num;
        longint    c;
        int        i;
        int        n;
        for (i = 0; i < NCOEF; i++)
        begin
            rom[i] = '0;
        end
        sum = 0;
        for (n = 0; n < TAPS; n++)
        begin
            sum = sum + kern_h(n);
        end
        if (sum <= 0)
        begin
            sum = 1;
        end
        for (n = 0; n < TAPS; n++)
        begin
            num = kern_h(n) * RATIO * 65536;
            if (num >= 0)
            begin
                c = div_trunc(num + sum / 2, sum);
            end
            else
            begin
                c = -div_trunc(-num + sum / 2, sum);
            end
            if (c > 131071)
            begin
                c = 131071;
            end
            if (c < -131072)
            begin
                c = -131072;
            end
            if (n / RATIO < PHASE_TAPS)
            begin
                rom[(n % RATIO) * PHASE_TAPS + n / RATIO] = CW'(c);
            end
        end
        return rom;
    endfunction

    localparam coef_rom_t COEF_ROM = build_rom();

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [PTR_W-1:0]        ptr_reg;
    logic [PTR_W-1:0]        ptr_next;
    logic [PTR_W-1:0]        ptr_inc;
    logic [PHASE_TAPS-1:0]   valid_reg;
    logic [PHASE_TAPS-1:0]   valid_next;
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [PTR_W-1:0]        rd_ptr_next;
    logic [PTR_W-1:0]        rd_dec;
    logic [PTR_W-1:0]        k_reg;
    logic [PTR_W-1:0]        k_next;
    logic [DCW-1:0]          j_reg;
    logic [DCW-1:0]          j_next;
    logic [BR_W-1:0]         p_reg;
    logic [BR_W-1:0]         p_next;
    logic [CIDX_W-1:0]       cidx_reg;
    logic [CIDX_W-1:0]       cidx_next;
    logic                    k_last;
    logic                    j_last;
    logic                    p_last;
    logic                    wr_en;
    pfi_pkg::mac_ctl_t       bctl_reg;
    pfi_pkg::mac_ctl_t       bctl_next;
    logic signed [CW-1:0]    coef_reg;
    logic                    vld_reg;
    logic [SW-1:0]           hist_rdata;
    pfi_pkg::mac_res_t       mres;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [SW-1:0]           out_data_reg;
    logic                    out_last_reg;

    assign ptr_inc = (ptr_reg == PTR_W'(PHASE_TAPS - 1)) ? '0 : ptr_reg + 1'b1;
    assign rd_dec  = (rd_ptr_reg == '0) ? PTR_W'(PHASE_TAPS - 1) : rd_ptr_reg - 1'b1;
    assign k_last  = (k_reg == PTR_W'(PHASE_TAPS - 1));
    assign j_last  = (j_reg == DCW'(pfi_pkg::DIGITS - 1));
    assign p_last  = (p_reg == BR_W'(RATIO - 1));

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        valid_next  = valid_reg;
        rd_ptr_next = rd_ptr_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        p_next      = p_reg;
        cidx_next   = cidx_reg;
        wr_en       = 1'b0;
        bctl_next   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    wr_en               = 1'b1;
                    ptr_next            = ptr_inc;
                    valid_next[ptr_inc] = 1'b1;
                    p_next              = '0;
                    cidx_next           = '0;
                    state_next          = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                // a branch starts only with the output word free, so its result has a place
                if (!out_valid_reg)
                begin
                    rd_ptr_next = ptr_reg;
                    k_next      = '0;
                    j_next      = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                bctl_next.valid   = 1'b1;
                bctl_next.digit   = j_reg;
                bctl_next.clear   = (k_reg == '0) && (j_reg == '0);
                bctl_next.done    = k_last && j_last;
                bctl_next.last_br = p_last;
                if (j_last)
                begin
                    j_next      = '0;
                    cidx_next   = cidx_reg + 1'b1;
                    rd_ptr_next = rd_dec;
                    if (k_last)
                    begin
                        k_next     = '0;
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (!bctl_reg.valid && !mres.busy)
                begin
                    if (p_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = ST_WAIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (mres.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= PTR_W'(PHASE_TAPS - 1);
            valid_reg     <= '0;
            rd_ptr_reg    <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            p_reg         <= '0;
            cidx_reg      <= '0;
            bctl_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            valid_reg     <= valid_next;
            rd_ptr_reg    <= rd_ptr_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            p_reg         <= p_next;
            cidx_reg      <= cidx_next;
            bctl_reg      <= bctl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Coefficient and history-valid flag line up with the registered memory read
    always_ff @(posedge clk)
    begin
        coef_reg <= COEF_ROM[cidx_reg];
        vld_reg  <= valid_reg[rd_ptr_reg];
        if (mres.valid)
        begin
            out_data_reg <= mres.sample;
            out_last_reg <= mres.last;
        end
    end

    pfi_ram #(
        .WIDTH (SW),
        .DEPTH (PHASE_TAPS)
    ) u_hist (
        .clk   (clk),
        .we    (wr_en),
        .waddr (ptr_inc),
        .wdata (s_tdata),
        .raddr (rd_ptr_reg),
        .rdata (hist_rdata)
    );

    pfi_mac #(
        .PHASE_TAPS (PHASE_TAPS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (bctl_reg),
        .coef   (coef_reg),
        .smp    (hist_rdata),
        .smp_ok (vld_reg),
        .res    (mres)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/pfi_checker.sv =====
// Port-level assertions for the polyphase FIR interpolator, bound to the top level.
module pfi_checker #(
    parameter int RATIO = pfi_pkg::RATIO_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pfi_pkg::SAMPLE_W-1:0]  m_tdata,
    input logic                          m_tlast
);

    localparam int CNT_W = $clog2(RATIO);

    logic [CNT_W-1:0] run_cnt_reg;
    logic [1:0]       pend_reg;
    logic             s_acc;
    logic             m_acc;

    assign s_acc = s_tvalid & s_tready;
    assign m_acc = m_tvalid & m_tready;

    // words delivered in the current run, and input words not yet finished
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg <= '0;
            pend_reg    <= '0;
        end
        else
        begin
            if (m_acc)
            begin
                run_cnt_reg <= m_tlast ? '0 : run_cnt_reg + 1'b1;
            end
            pend_reg <= pend_reg + {1'b0, s_acc} - {1'b0, m_acc & m_tlast};
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> !s_tready)
        else $error("second input word taken before the first was processed");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_acc && m_tlast |-> run_cnt_reg == CNT_W'(RATIO - 1))
        else $error("run did not hold RATIO words");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        m_acc |-> pend_reg != 2'd0)
        else $error("output word with no input word pending");

endmodule

bind polyphase_fir_interpolator_top pfi_checker #(
    .RATIO (RATIO)
) u_pfi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/polyphase_fir_interpolator_top_tb.sv =====
// Self-checking testbench for the polyphase FIR interpolator: random bursty stream, scoreboard.
`timescale 1ns / 100ps

module polyphase_fir_interpolator_top_tb;

    localparam int SAMPLE_W = pfi_pkg::SAMPLE_W;
    localparam int COEF_W   = pfi_pkg::COEF_W;

    localparam int RATIO      = pfi_pkg::RATIO_DEF;
    localparam int TAPS       = pfi_pkg::TAPS_DEF;
    localparam int PHASE_TAPS = pfi_pkg::PHASE_TAPS_DEF;
    localparam int N_COEF     = RATIO * PHASE_TAPS;

    localparam int RANDOM_WORDS   = 480;
    localparam int PRESSURE_AT    = 200;    // input word index where the sink holds off
    localparam int HOLD_CYCLES    = 1500;
    localparam int DRAIN_CYCLES   = 500;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS    = 10;

    localparam logic [SAMPLE_W-1:0] S_MAX = 24'h7F_FFFF;
    localparam logic [SAMPLE_W-1:0] S_MIN = 24'h80_0000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } out_word_t;

    // Predicts the output words from the accepted input words and checks them in order.
    class interp_scoreboard;
        localparam longint unsigned Q_ONE       = 64'd1073741824;
        localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
        localparam longint          Q_ONE_S     = 64'sd1073741824;
        localparam longint          PI_Q30      = 64'sd3373259426;
        localparam longint          WIN_A0      = (longint'(42) << 30) / 100;
        localparam longint          WIN_A1      = (longint'(50) << 30) / 100;
        localparam longint          WIN_A2      = (longint'(8) << 30) / 100;

        logic signed [SAMPLE_W-1:0] hist [PHASE_TAPS];
        int unsigned                newest;
        logic signed [COEF_W-1:0]   coef [N_COEF];
        out_word_t                  due_words [$];
        int                         n_in;
        int                         n_out;
        int                         n_bad;
        int                         n_clip;

        function new();
            foreach (hist[i]) hist[i] = '0;
            newest = PHASE_TAPS - 1;
            n_in   = 0;
            n_out  = 0;
            n_bad  = 0;
            n_clip = 0;
            build_kernel();
        endfunction

        // sin(2*pi*num/den) in Q30: quadrant fold, then odd Taylor series to x^11
        function longint sine_q30(longint num, longint den);
            longint          r;
            longint unsigned ph, f, x, x2, t, s;
            logic [1:0]      quad;
            r = num % den;
            if (r < 0) r = r + den;
            ph   = ($unsigned(r) << 32) / $unsigned(den);
            quad = ph[31:30];
            f    = ph & 64'h3FFF_FFFF;
            if (quad[0]) f = Q_ONE - f;
            x  = (f * HALF_PI_Q30) >> 30;
            x2 = (x * x) >> 30;
            t  = Q_ONE;
            t  = Q_ONE - ((x2 * t) >> 30) / 110;
            t  = Q_ONE - ((x2 * t) >> 30) / 72;
            t  = Q_ONE - ((x2 * t) >> 30) / 42;
            t  = Q_ONE - ((x2 * t) >> 30) / 20;
            t  = Q_ONE - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            return quad[1] ? -$signed(s) : $signed(s);
        endfunction

        function longint qmul30(longint a, longint b);
            return (a * b) / Q_ONE_S;
        endfunction

        // Blackman-windowed sinc, normalized to RATIO in Q2.16, split into branches
        function void build_kernel();
            longint h [TAPS];
            longint total, d, g, w, num, c;
            total = 0;
            foreach (coef[i]) coef[i] = '0;
            for (int n = 0; n < TAPS; n++)
            begin
                d = longint'(n) - longint'((TAPS - 1) / 2);
                if (d == 0) g = PI_Q30 / RATIO;
                else        g = sine_q30(d, 2 * RATIO) / d;
                w = WIN_A0 - qmul30(WIN_A1, sine_q30(4 * n + (TAPS - 1), 4 * (TAPS - 1)))
                    + qmul30(WIN_A2, sine_q30(8 * n + (TAPS - 1), 4 * (TAPS - 1)));
                h[n] = qmul30(g, w);
                total += h[n];
            end
            if (total <= 0) total = 1;
            for (int n = 0; n < TAPS; n++)
            begin
                num = h[n] * RATIO * 65536;
                if (num >= 0) c = (num + total / 2) / total;
                else          c = -((-num + total / 2) / total);
                if (c > 131071)  c = 131071;
                if (c < -131072) c = -131072;
                if (n / RATIO < PHASE_TAPS)
                    coef[(n % RATIO) * PHASE_TAPS + n / RATIO] = c[COEF_W-1:0];
            end
        endfunction

        function void take_sample(logic [SAMPLE_W-1:0] word);
            longint      acc, q;
            int unsigned idx;
            out_word_t   exp_word;
            newest       = (newest + 1) % PHASE_TAPS;
            hist[newest] = word;
            n_in++;
            for (int p = 0; p < RATIO; p++)
            begin
                acc = 0;
                for (int k = 0; k < PHASE_TAPS; k++)
                begin
                    idx = (newest + PHASE_TAPS - k) % PHASE_TAPS;
                    acc += longint'(coef[p * PHASE_TAPS + k]) * longint'(hist[idx]);
                end
                // round half up from Q3.39, then clip to 24 bits
                q = (acc + 32768) >>> 16;
                if (q > 8388607 || q < -8388608) n_clip++;
                if (q > 8388607)  q = 8388607;
                if (q < -8388608) q = -8388608;
                exp_word.sample = q[SAMPLE_W-1:0];
                exp_word.last   = (p == RATIO - 1);
                due_words.push_back(exp_word);
            end
        endfunction

        function void report(string exp_txt, logic [SAMPLE_W-1:0] data, logic last);
            n_bad++;
            if (n_bad <= MAX_REPORTS)
                $display("%0t: output word %0d: expected %s, got sample %06h last %0b",
                         $time, n_out, exp_txt, data, last);
        endfunction

        function void check_word(logic [SAMPLE_W-1:0] data, logic last);
            out_word_t exp_word;
            if (due_words.size() == 0)
                report("no word", data, last);
            else
            begin
                exp_word = due_words.pop_front();
                if (exp_word.sample !== data || exp_word.last !== last)
                    report($sformatf("sample %06h last %0b", exp_word.sample, exp_word.last),
                           data, last);
            end
            n_out++;
        endfunction
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_tdata;
    logic                m_tlast;

    bit                  hold_req = 1'b0;
    logic [SAMPLE_W-1:0] stim_q [$];
    interp_scoreboard    fir;

    polyphase_fir_interpolator_top #(
        .RATIO      (RATIO),
        .TAPS       (TAPS),
        .PHASE_TAPS (PHASE_TAPS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Words whose signs follow branch 0's taps, so the dot product peaks and clips
    task automatic push_aligned(input int len, input bit negate, input logic [SAMPLE_W-1:0] amp);
        logic [SAMPLE_W-1:0] word;
        for (int j = 0; j < len; j++)
        begin
            if (fir.coef[len - 1 - j] == 0)
                word = SAMPLE_W'($urandom());
            else if ((fir.coef[len - 1 - j] > 0) ^ negate)
                word = amp;
            else
                word = ~amp;
            stim_q.push_back(word);
        end
    endtask

    task automatic build_stimulus();
        int kind, len, n_rand;
        logic [SAMPLE_W-1:0] word;
        // directed: zero, both extremes, unit steps, alternating bits, then a clipping run
        stim_q.push_back('0);
        stim_q.push_back(S_MAX);
        stim_q.push_back(S_MIN);
        stim_q.push_back(24'h00_0001);
        stim_q.push_back(24'hFF_FFFF);
        stim_q.push_back(24'h55_5555);
        stim_q.push_back(24'hAA_AAAA);
        stim_q.push_back(S_MAX);
        push_aligned(16, 1'b0, S_MAX);

        n_rand = 0;
        while (n_rand < RANDOM_WORDS)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                len = $urandom_range(1, 40);
                repeat (len) stim_q.push_back(SAMPLE_W'($urandom()));
            end
            else if (kind <= 7)
            begin
                len = PHASE_TAPS;
                push_aligned(len, 1'($urandom_range(0, 1)),
                             SAMPLE_W'($urandom_range(6000000, 8388607)));
            end
            else
            begin
                len = $urandom_range(1, 12);
                repeat (len)
                begin
                    case ($urandom_range(0, 5))
                        0:       word = '0;
                        1:       word = S_MAX;
                        2:       word = S_MIN;
                        3:       word = 24'h00_0001;
                        4:       word = 24'hFF_FFFF;
                        default: word = SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
                    endcase
                    stim_q.push_back(word);
                end
            end
            n_rand += len;
        end
    endtask

    // Entered at a falling edge, returns at the falling edge after the word is taken
    task automatic push_sample(input logic [SAMPLE_W-1:0] word);
        s_tdata  = word;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        fir.take_sample(word);
        @(negedge clk);
    endtask

    task automatic drive_stream();
        int burst, gap, steady;
        burst  = $urandom_range(1, 24);
        steady = 0;
        foreach (stim_q[i])
        begin
            if (i == PRESSURE_AT)
            begin
                hold_req = 1'b1;
                steady   = 40;   // keep offering while the sink is held off
            end
            push_sample(stim_q[i]);
            if (steady > 0)
                steady--;
            else
            begin
                burst--;
                if (burst == 0)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: gap = $urandom_range(1, 4);
                        3, 4, 5: gap = $urandom_range(5, 120);
                        6, 7, 8: gap = $urandom_range(120, 250);
                        default: gap = $urandom_range(250, 400);
                    endcase
                    s_tvalid = 1'b0;
                    repeat (gap) @(negedge clk);
                    burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                        : $urandom_range(1, 24);
                end
            end
        end
        s_tvalid = 1'b0;
    endtask

    // Sink: checks taken words at the rising edge, picks tready at the falling edge
    initial
    begin
        int mode, left, stall;
        mode  = 0;
        left  = 0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready) fir.check_word(m_tdata, m_tlast);
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 400);
            end
            left--;
            case (mode)
                0:       m_tready = 1'b1;
                1:       m_tready = 1'($urandom_range(0, 1));
                default:
                begin
                    if (stall > 0)
                    begin
                        stall--;
                        m_tready = 1'b0;
                    end
                    else
                    begin
                        m_tready = 1'b1;
                        if ($urandom_range(0, 3) == 0) stall = $urandom_range(1, 30);
                    end
                end
            endcase
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
            if (idle >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        fir = new();
        build_stimulus();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        drive_stream();
        while (fir.due_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d input words through the interpolator, checked %0d output words.",
                 fir.n_in, fir.n_out);
        $display("Covered clipping (%0d clipped words), bursty input, %0d-cycle sink hold-off.",
                 fir.n_clip, HOLD_CYCLES);
        if (fir.n_bad == 0 && fir.due_words.size() == 0)
            $display("Test completed successfully");
        else
        begin
            $display("%0d mismatches, %0d words still due", fir.n_bad, fir.due_words.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
